[src/three_level_ready_queue_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the three-level ready queue
// Clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef THREE_LEVEL_READY_QUEUE_CORE_ASSERT_SVH
`define THREE_LEVEL_READY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication
`define TLRQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlrq: same-cycle check failed");

// Next-cycle implication
`define TLRQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlrq: next-cycle check failed");

`endif

[src/tlrq_pkg.sv]
// ---------------------------------------------------------------------------
// tlrq_pkg
// Codes, entry and candidate types shared by the ready queue modules.
// ---------------------------------------------------------------------------
package tlrq_pkg;

  // Command codes on the input word
  localparam logic CMD_INSERT   = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INSERTED   = 2'd0;
  localparam logic [1:0] ST_DISPATCHED = 2'd1;
  localparam logic [1:0] ST_NONE       = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  // Level codes
  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_1    = 2'd1;
  localparam logic [1:0] LVL_2    = 2'd2;
  localparam logic [1:0] LVL_3    = 2'd3;

  // Configuration register map
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_L3_TOP = 2'd0;
  localparam logic [CFG_IW-1:0] REG_L2_TOP = 2'd1;
  localparam logic [7:0] L3_TOP_RST = 8'd49;
  localparam logic [7:0] L2_TOP_RST = 8'd99;

  // One stored thread
  typedef struct packed {
    logic [1:0]  level;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [7:0]  id;
  } entry_t;

  // Best-so-far candidates of the three levels, walked down the chain
  typedef struct packed {
    logic        found1;
    logic [15:0] burst1;
    logic [7:0]  id1;
    logic        found2;
    logic [7:0]  prio2;
    logic [7:0]  id2;
    logic        found3;
    logic [7:0]  id3;
  } cand_t;

  // Table update strobes broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic rm_en;
  } cell_ctl_t;

endpackage

[src/tlrq_cell.sv]
// ---------------------------------------------------------------------------
// tlrq_cell
// One table slot: holds an entry, takes an insert when it is the first free
// slot, shifts down from its upper neighbor on removal, and folds its entry
// into the candidate word that walks the chain one cell per cycle.
// ---------------------------------------------------------------------------
module tlrq_cell #(
  parameter int ENTRIES = 16,
  parameter int IDX     = 0,
  localparam int IW     = $clog2(ENTRIES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tlrq_pkg::cell_ctl_t ctl_i,
  input  tlrq_pkg::entry_t    new_i,
  input  logic [IW-1:0]       rm_idx_i,
  input  logic                prv_valid_i,
  input  logic                nxt_valid_i,
  input  tlrq_pkg::entry_t    nxt_entry_i,
  output logic                valid_o,
  output tlrq_pkg::entry_t    entry_o,
  input  logic                tok_i,
  input  tlrq_pkg::cand_t     cand_i,
  input  logic [2:0][IW-1:0]  cidx_i,
  output logic                tok_o,
  output tlrq_pkg::cand_t     cand_o,
  output logic [2:0][IW-1:0]  cidx_o
);
  import tlrq_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic              valid_r, valid_nxt;
  entry_t            entry_r, entry_nxt;
  logic              tok_r;
  cand_t             cand_r, cand_nxt;
  logic [2:0][IW-1:0] cidx_r, cidx_nxt;
  logic              mine1, mine2, mine3;
  logic              take1, take2, take3;

  // Shift down on removal, load on insert into the first free slot
  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (ctl_i.rm_en && (MY_IDX >= rm_idx_i)) begin
      valid_nxt = nxt_valid_i;
      entry_nxt = nxt_entry_i;
    end else if (ctl_i.ins_en && !valid_r && prv_valid_i) begin
      valid_nxt = 1'b1;
      entry_nxt = new_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // Fold this entry into the incoming candidates; ties go to the lower id, level 3 keeps the earliest slot
  always_comb begin
    mine1 = valid_r && (entry_r.level == LVL_1);
    mine2 = valid_r && (entry_r.level == LVL_2);
    mine3 = valid_r && (entry_r.level == LVL_3);
    take1 = mine1 && (!cand_i.found1 || (entry_r.burst < cand_i.burst1) ||
             ((entry_r.burst == cand_i.burst1) && (entry_r.id < cand_i.id1)));
    take2 = mine2 && (!cand_i.found2 || (entry_r.prio > cand_i.prio2) ||
             ((entry_r.prio == cand_i.prio2) && (entry_r.id < cand_i.id2)));
    take3 = mine3 && !cand_i.found3;
    cand_nxt = cand_i;
    cidx_nxt = cidx_i;
    if (take1) begin
      cand_nxt.found1 = 1'b1;
      cand_nxt.burst1 = entry_r.burst;
      cand_nxt.id1    = entry_r.id;
      cidx_nxt[0]     = MY_IDX;
    end
    if (take2) begin
      cand_nxt.found2 = 1'b1;
      cand_nxt.prio2  = entry_r.prio;
      cand_nxt.id2    = entry_r.id;
      cidx_nxt[1]     = MY_IDX;
    end
    if (take3) begin
      cand_nxt.found3 = 1'b1;
      cand_nxt.id3    = entry_r.id;
      cidx_nxt[2]     = MY_IDX;
    end
  end

  // Advance the search token and its candidates to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_i;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_i) begin
      cand_r <= cand_nxt;
      cidx_r <= cidx_nxt;
    end
  end

  assign valid_o = valid_r;
  assign entry_o = entry_r;
  assign tok_o   = tok_r;
  assign cand_o  = cand_r;
  assign cidx_o  = cidx_r;

endmodule

[src/three_level_ready_queue_core.sv]
// ---------------------------------------------------------------------------
// three_level_ready_queue_core
// Three-level ready-thread table built as a row of slot cells.
//
//   channel  dir  handshake               payload
//   in_      in   in_tvalid / in_tready   tdata: id, priority, burst; tuser: cmd
//   out_     out  out_tvalid / out_tready tdata: chosen id, level; tuser: status
//   cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Insert: slot written at accept; the result goes to the result register, then the output register.
// Dispatch: a token walks the cell row one slot per cycle, then a single shift removes the
// chosen slot as the result is registered.
// Reset empties the table at once (valid flops) and loads limits 49 and 99.
// One result may wait in the output register while the next word is worked on;
// the one after that finishes and holds until the output register frees up.
// ---------------------------------------------------------------------------
module three_level_ready_queue_core #(
  parameter int ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // [7:0] thread_id, [15:8] thread_priority,
                                                   // [31:16] burst_left
  input  logic [0:0]                   in_tuser,   // [0] cmd
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,  // [7:0] chosen_id, [9:8] chosen_level,
                                                   // [15:10] zero
  output logic [1:0]                   out_tuser,  // [1:0] status
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tlrq_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [7:0]                   cfg_data
);
  import tlrq_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  l3_top_r, l2_top_r;
  logic [1:0]  res_status_r, res_status_nxt;
  logic [7:0]  res_id_r, res_id_nxt;
  logic [1:0]  res_lvl_r, res_lvl_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r;
  logic [7:0]  out_id_r;
  logic [1:0]  out_lvl_r;
  logic        out_load;

  logic        in_acc;
  logic        cmd;
  logic [7:0]  in_id;
  logic [7:0]  in_prio;
  logic [15:0] in_burst;
  logic [1:0]  ins_lvl;
  logic        full;
  logic        scan_end;
  entry_t      new_entry;
  cell_ctl_t   ctl;
  logic [IW-1:0] rm_idx;
  logic        sel_found;
  logic [1:0]  sel_status;
  logic [7:0]  sel_id;
  logic [1:0]  sel_lvl;

  entry_t             ent_c  [ENTRIES+1];
  logic [ENTRIES:0]   vld_c;
  logic [ENTRIES-1:0] prv_c;
  logic [ENTRIES:0]   tok_c;
  cand_t              cand_c [ENTRIES+1];
  logic [2:0][IW-1:0] cidx_c [ENTRIES+1];

  // Unpack the input word
  assign cmd      = in_tuser[0];
  assign in_id    = in_tdata[7:0];
  assign in_prio  = in_tdata[15:8];
  assign in_burst = in_tdata[31:16];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l3_top_r <= L3_TOP_RST;
      l2_top_r <= L2_TOP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_L3_TOP: l3_top_r <= cfg_data;
        REG_L2_TOP: l2_top_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the level of an inserted thread
  always_comb begin
    if (in_prio <= l3_top_r) begin
      ins_lvl = LVL_3;
    end else if (in_prio <= l2_top_r) begin
      ins_lvl = LVL_2;
    end else begin
      ins_lvl = LVL_1;
    end
  end

  assign new_entry = '{level: ins_lvl, burst: in_burst, prio: in_prio, id: in_id};
  assign full      = vld_c[ENTRIES-1];
  assign scan_end  = (state_r == S_SCAN) && tok_c[ENTRIES];

  // Serve the first level that has a candidate
  always_comb begin
    rm_idx     = '0;
    sel_found  = 1'b1;
    sel_status = ST_DISPATCHED;
    sel_id     = 8'd0;
    sel_lvl    = LVL_NONE;
    if (cand_c[ENTRIES].found1) begin
      rm_idx  = cidx_c[ENTRIES][0];
      sel_id  = cand_c[ENTRIES].id1;
      sel_lvl = LVL_1;
    end else if (cand_c[ENTRIES].found2) begin
      rm_idx  = cidx_c[ENTRIES][1];
      sel_id  = cand_c[ENTRIES].id2;
      sel_lvl = LVL_2;
    end else if (cand_c[ENTRIES].found3) begin
      rm_idx  = cidx_c[ENTRIES][2];
      sel_id  = cand_c[ENTRIES].id3;
      sel_lvl = LVL_3;
    end else begin
      sel_found  = 1'b0;
      sel_status = ST_NONE;
    end
  end

  assign ctl.ins_en = in_acc && (cmd == CMD_INSERT) && !full;
  assign ctl.rm_en  = scan_end && sel_found;

  // Chain ends
  assign ent_c[ENTRIES] = '0;
  assign vld_c[ENTRIES] = 1'b0;
  assign prv_c          = {vld_c[ENTRIES-2:0], 1'b1};
  assign tok_c[0]       = in_acc && (cmd == CMD_DISPATCH);
  assign cand_c[0]      = '0;
  assign cidx_c[0]      = '0;

  // Row of slot cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tlrq_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl_i       (ctl),
      .new_i       (new_entry),
      .rm_idx_i    (rm_idx),
      .prv_valid_i (prv_c[i]),
      .nxt_valid_i (vld_c[i+1]),
      .nxt_entry_i (ent_c[i+1]),
      .valid_o     (vld_c[i]),
      .entry_o     (ent_c[i]),
      .tok_i       (tok_c[i]),
      .cand_i      (cand_c[i]),
      .cidx_i      (cidx_c[i]),
      .tok_o       (tok_c[i+1]),
      .cand_o      (cand_c[i+1]),
      .cidx_o      (cidx_c[i+1])
    );
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Sequencer: accept, search on a dispatch, hand the result to the output register
  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_lvl_nxt    = res_lvl_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_INSERT: begin
              state_nxt  = S_DONE;
              res_id_nxt = 8'd0;
              if (full) begin
                res_status_nxt = ST_FULL;
                res_lvl_nxt    = LVL_NONE;
              end else begin
                res_status_nxt = ST_INSERTED;
                res_lvl_nxt    = ins_lvl;
              end
            end
            CMD_DISPATCH: begin
              state_nxt = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt      = S_DONE;
          res_status_nxt = sel_status;
          res_id_nxt     = sel_id;
          res_lvl_nxt    = sel_lvl;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_lvl_r    <= res_lvl_nxt;
  end

  // Output register: hold while stalled, load a finished result
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_lvl_r    <= res_lvl_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_lvl_r, out_id_r};
  assign out_tuser  = out_status_r;

endmodule

[src/tlrq_checker.sv]
// ---------------------------------------------------------------------------
// tlrq_checker
// Port-level checks on the result channel of the ready queue.
// ---------------------------------------------------------------------------
`include "three_level_ready_queue_core_assert.svh"

module tlrq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import tlrq_pkg::*;

  logic [1:0] res_st;
  logic [7:0] res_id;
  logic [1:0] res_lvl;
  logic       res_named;
  logic       pad_zero;

  // Split the result word into its fields
  assign res_st    = out_tuser;
  assign res_id    = out_tdata[7:0];
  assign res_lvl   = out_tdata[9:8];
  assign res_named = (res_st == ST_INSERTED) || (res_st == ST_DISPATCHED);
  assign pad_zero  = (out_tdata[15:10] == 6'd0);

  // Only a dispatch names a thread
  `TLRQ_ASSERT_IMP(a_id_zero, out_tvalid && (res_st != ST_DISPATCHED), res_id == 8'd0)

  // Nothing ready and full table carry no level
  `TLRQ_ASSERT_IMP(a_lvl_none, out_tvalid && !res_named, res_lvl == LVL_NONE)

  // Insert and dispatch always name a real level, padding stays zero
  `TLRQ_ASSERT_IMP(a_lvl_real, out_tvalid && res_named, (res_lvl != LVL_NONE) && pad_zero)

  // A stalled result holds
  `TLRQ_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind three_level_ready_queue_core tlrq_checker u_tlrq_checker (.*);
